// ===== design/periodic_release_dispatcher_top_defines.svh =====
// assertion macros used by the checker file
`ifndef PERIODIC_RELEASE_DISPATCHER_TOP_DEFINES_SVH
`define PERIODIC_RELEASE_DISPATCHER_TOP_DEFINES_SVH

// implication in the same cycle, sampled on the rising clock
`define PRD_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// implication in the next cycle
`define PRD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/prd_pkg.sv =====
package prd_pkg;

  localparam int unsigned NOW_W       = 8;
  localparam int unsigned SPEC_W      = 16;
  localparam int unsigned SPEC_CNT    = 4;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned TASK_W      = 2;
  localparam int unsigned SLEEP_W     = 7;
  localparam int unsigned FAULT_W     = 3;
  localparam int unsigned KIND_W      = 2;
  localparam int unsigned IN_TDATA_W  = 8;
  localparam int unsigned OUT_TDATA_W = 16;
  localparam int unsigned OUT_TUSER_W = 2;

  localparam logic [SLEEP_W-1:0] SLEEP_CAP = 7'd127;

  // fault bit positions
  localparam int unsigned FLT_CONFIG = 0;
  localparam int unsigned FLT_LATE   = 1;
  localparam int unsigned FLT_SKIP   = 2;

  typedef enum logic [KIND_W-1:0] {
    KIND_START  = 2'd0,
    KIND_FINISH = 2'd1,
    KIND_RESET  = 2'd2
  } kind_e;

  typedef enum logic [7:0] {
    S_IDLE     = 8'b0000_0001,
    S_CLR      = 8'b0000_0010,
    S_SCAN_RD  = 8'b0000_0100,
    S_SCAN_CHK = 8'b0000_1000,
    S_FIN_CHK  = 8'b0001_0000,
    S_MIN_RD   = 8'b0010_0000,
    S_MIN_ACC  = 8'b0100_0000,
    S_EMIT     = 8'b1000_0000
  } state_e;

  typedef struct packed {
    logic               run_request;
    logic [TASK_W-1:0]  run_task;
    logic               pass_done;
    logic [SLEEP_W-1:0] wake_ticks;
    logic               out_of_order;
  } res_t;

  // due when now - rel, mod 256, is below 128
  function automatic logic is_due(logic [NOW_W-1:0] now, logic [NOW_W-1:0] rel);
    logic [NOW_W-1:0] diff;
    diff = now - rel;
    return !diff[NOW_W-1];
  endfunction

  // 0 < period < 128 and 0 < deadline <= period
  function automatic logic spec_ok(logic [SPEC_W-1:0] spec);
    logic [NOW_W-1:0] per;
    logic [NOW_W-1:0] dl;
    per = spec[NOW_W-1:0];
    dl  = spec[SPEC_W-1:NOW_W];
    return (per != '0) && !per[NOW_W-1] && (dl != '0) && (dl <= per);
  endfunction

endpackage

// ===== design/periodic_release_dispatcher_top.sv =====
// Periodic release dispatcher. Keeps an 8-bit wrapping release tick per task in a
// small synchronous RAM (one read and one write port, registered read data)
// and walks the tasks one dispatch pass at a time. A start beat scans tasks in
// index order; the first due task gets a run request beat and the block waits for
// a finished beat, which advances that task's release by its period and resumes the
// scan. A pass ends with a pass_done beat (tlast) carrying the ticks until the next
// release, capped at 127, or 0 while the config fault is set. Out-of-phase start or
// finish beats get out_of_order and change nothing; kind 3 is ignored. Each beat is
// handled one at a time, and the RAM read-modify-write loop sets the pace. A scanned
// task takes a read and a check step, a finished beat adds a write back, and a pass ends
// with the end-of-scan check, a read and accumulate sweep over every task for the sleep
// value and the hand-off to the output register. A reset beat rewrites every entry in
// turn; out-of-phase and ignored beats go straight to the emit state. A stalled output
// register holds the block in its emit state. Release ticks read as 0 after rst_ni
// until first written. The user must write task specs through cfg_we_i / cfg_idx_i /
// cfg_wdata_i only while the block is idle; the block itself does not enforce it.
module periodic_release_dispatcher_top #(
  parameter int unsigned TASKS = 4
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // config write port: index selects task_spec_0..3
  input  logic                               cfg_we_i,
  input  logic [prd_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [prd_pkg::SPEC_W-1:0]         cfg_wdata_i,
  // input stream
  input  logic                               s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  input  logic [prd_pkg::IN_TDATA_W-1:0]     s_axis_tdata_i,   // now[7:0]
  input  logic [prd_pkg::KIND_W-1:0]         s_axis_tuser_i,   // kind[1:0]
  // result stream
  output logic                               m_axis_tvalid_o,
  input  logic                               m_axis_tready_i,
  output logic [prd_pkg::OUT_TDATA_W-1:0]    m_axis_tdata_o,   // run_task[1:0],
                                                               // wake_ticks[8:2],
                                                               // fault_flags[11:9], zero pad
  output logic [prd_pkg::OUT_TUSER_W-1:0]    m_axis_tuser_o,   // run_request[0],
                                                               // out_of_order[1]
  output logic                               m_axis_tlast_o    // pass_done
);
  import prd_pkg::*;

  localparam int unsigned AW = (TASKS > 1) ? $clog2(TASKS) : 1;  // ram address
  localparam int unsigned CW = $clog2(TASKS + 1);                // counts 0..TASKS

  // config registers, all four kept
  logic [SPEC_W-1:0] spec_q [SPEC_CNT];

  // release tick ram and per-entry valid bits (entry reads 0 until written)
  logic [NOW_W-1:0] mem [TASKS];
  logic [TASKS-1:0] vld_q;
  logic [NOW_W-1:0] rdata_q;
  logic             rd_vld_q;
  logic [AW-1:0]    raddr;
  logic             mem_we;
  logic [AW-1:0]    waddr;
  logic [NOW_W-1:0] wdata;

  // control
  state_e             state_q, state_d;
  logic [CW-1:0]      scan_q, scan_d;      // next task to scan, or running task
  logic [CW-1:0]      idx_q, idx_d;        // sweep counter for clear and min
  logic               await_q, await_d;
  logic [FAULT_W-1:0] fault_q, fault_d;
  logic [SLEEP_W-1:0] best_q, best_d;
  logic [NOW_W-1:0]   now_q, now_d;
  res_t               res_q, res_d;

  // output register
  logic                   out_vld_q;
  logic [OUT_TDATA_W-1:0] out_data_q;
  logic [OUT_TUSER_W-1:0] out_user_q;
  logic                   out_last_q;

  logic               in_acc;
  kind_e              kind;
  logic [NOW_W-1:0]   rel;
  logic [SPEC_W-1:0]  cur_spec;
  logic [NOW_W-1:0]   period;
  logic [NOW_W-1:0]   late;
  logic [NOW_W-1:0]   adv;
  logic [NOW_W-1:0]   gap_ticks;
  logic [SLEEP_W-1:0] best_new;
  logic               sweep_last;
  logic               out_free;

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;
  assign kind            = kind_e'(s_axis_tuser_i);

  assign rel       = rd_vld_q ? rdata_q : '0;
  assign cur_spec  = spec_q[TASK_W'(scan_q)];
  assign period    = cur_spec[NOW_W-1:0];
  assign late      = now_q - rel;
  assign adv       = rel + period;
  assign gap_ticks = is_due(now_q, rel) ? '0 : (rel - now_q);
  assign best_new  = (gap_ticks < {1'b0, best_q}) ? gap_ticks[SLEEP_W-1:0] : best_q;
  assign sweep_last = (idx_q == CW'(TASKS - 1));
  assign out_free = !out_vld_q || m_axis_tready_i;

  // config writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < SPEC_CNT; i++) spec_q[i] <= '0;
    end else if (cfg_we_i) begin
      spec_q[cfg_idx_i] <= cfg_wdata_i;
    end
  end

  // ram: synchronous read, registered read data
  always_ff @(posedge clk_i) begin
    if (mem_we) mem[waddr] <= wdata;
    rdata_q <= mem[raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      rd_vld_q <= vld_q[raddr];
      if (mem_we) vld_q[waddr] <= 1'b1;
    end
  end

  always_comb begin
    state_d = state_q;
    scan_d  = scan_q;
    idx_d   = idx_q;
    await_d = await_q;
    fault_d = fault_q;
    best_d  = best_q;
    now_d   = now_q;
    res_d   = res_q;
    raddr   = AW'(scan_q);
    mem_we  = 1'b0;
    waddr   = AW'(idx_q);
    wdata   = now_q;

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          now_d = s_axis_tdata_i;
          res_d = '0;
          unique case (kind)
            KIND_RESET: begin
              fault_d = '0;
              scan_d  = '0;
              await_d = 1'b0;
              idx_d   = '0;
              state_d = S_CLR;
            end
            KIND_START: begin
              if (await_q) begin
                res_d.out_of_order = 1'b1;
                state_d = S_EMIT;
              end else begin
                scan_d  = '0;
                state_d = S_SCAN_RD;
              end
            end
            KIND_FINISH: begin
              if (!await_q) begin
                res_d.out_of_order = 1'b1;
                state_d = S_EMIT;
              end else begin
                // read of the running task issued here
                state_d = S_FIN_CHK;
              end
            end
            default: state_d = S_EMIT;   // kind 3, ignored
          endcase
        end
      end

      S_CLR: begin
        mem_we = 1'b1;
        waddr  = AW'(idx_q);
        wdata  = now_q;
        idx_d  = idx_q + 1'b1;
        if (sweep_last) state_d = S_EMIT;
      end

      S_SCAN_RD: begin
        raddr = AW'(scan_q);
        if (scan_q == CW'(TASKS)) begin
          idx_d   = '0;
          best_d  = SLEEP_CAP;
          state_d = S_MIN_RD;
        end else begin
          state_d = S_SCAN_CHK;
        end
      end

      S_SCAN_CHK: begin
        if (!spec_ok(cur_spec)) begin
          fault_d[FLT_CONFIG] = 1'b1;
          scan_d  = scan_q + 1'b1;
          state_d = S_SCAN_RD;
        end else if (is_due(now_q, rel)) begin
          if (late >= cur_spec[SPEC_W-1:NOW_W]) fault_d[FLT_LATE] = 1'b1;
          await_d = 1'b1;
          res_d.run_request = 1'b1;
          res_d.run_task    = TASK_W'(scan_q);
          state_d = S_EMIT;
        end else begin
          scan_d  = scan_q + 1'b1;
          state_d = S_SCAN_RD;
        end
      end

      S_FIN_CHK: begin
        // write back the advanced release, next read is another entry
        mem_we = 1'b1;
        waddr  = AW'(scan_q);
        wdata  = adv;
        if (is_due(now_q, adv)) begin
          fault_d[FLT_SKIP] = 1'b1;
          wdata = now_q + period;
        end
        await_d = 1'b0;
        scan_d  = scan_q + 1'b1;
        state_d = S_SCAN_RD;
      end

      S_MIN_RD: begin
        raddr   = AW'(idx_q);
        state_d = S_MIN_ACC;
      end

      S_MIN_ACC: begin
        best_d = best_new;
        idx_d  = idx_q + 1'b1;
        if (sweep_last) begin
          res_d.pass_done  = 1'b1;
          res_d.wake_ticks = fault_q[FLT_CONFIG] ? '0 : best_new;
          scan_d  = '0;
          await_d = 1'b0;
          state_d = S_EMIT;
        end else begin
          state_d = S_MIN_RD;
        end
      end

      S_EMIT: begin
        if (out_free) state_d = S_IDLE;
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      scan_q  <= '0;
      idx_q   <= '0;
      await_q <= 1'b0;
      fault_q <= '0;
    end else begin
      state_q <= state_d;
      scan_q  <= scan_d;
      idx_q   <= idx_d;
      await_q <= await_d;
      fault_q <= fault_d;
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk_i) begin
    best_q <= best_d;
    now_q  <= now_d;
    res_q  <= res_d;
  end

  // output register, loads from the emit state once the slot is free
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (state_q == S_EMIT && out_free) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_EMIT && out_free) begin
      out_data_q <= {{(OUT_TDATA_W - FAULT_W - SLEEP_W - TASK_W){1'b0}},
                     fault_q, res_q.wake_ticks, res_q.run_task};
      out_user_q <= {res_q.out_of_order, res_q.run_request};
      out_last_q <= res_q.pass_done;
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tuser_o  = out_user_q;
  assign m_axis_tlast_o  = out_last_q;

endmodule

// ===== design/prd_checker.sv =====
`include "periodic_release_dispatcher_top_defines.svh"

module prd_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            m_axis_tvalid_o,
  input logic                            m_axis_tready_i,
  input logic [prd_pkg::OUT_TDATA_W-1:0] m_axis_tdata_o,
  input logic [prd_pkg::OUT_TUSER_W-1:0] m_axis_tuser_o,
  input logic                            m_axis_tlast_o
);
  import prd_pkg::*;

  // a stalled result beat stays offered
  `PRD_ASSERT_NEXT(a_hold, clk_i, rst_ni, m_axis_tvalid_o && !m_axis_tready_i, m_axis_tvalid_o, "result beat dropped while stalled")

  // run request, pass end and out-of-order marking are exclusive
  `PRD_ASSERT_NOW(a_excl, clk_i, rst_ni, m_axis_tvalid_o, !(m_axis_tuser_o[0] && m_axis_tlast_o) && !(m_axis_tuser_o[1] && (m_axis_tuser_o[0] || m_axis_tlast_o)), "conflicting result kinds")

  // sleep ticks only at pass end and never with the config fault
  `PRD_ASSERT_NOW(a_sleep, clk_i, rst_ni, m_axis_tvalid_o && (m_axis_tdata_o[8:2] != '0), m_axis_tlast_o && !m_axis_tdata_o[9], "sleep ticks outside a clean pass end")

  // a task index only rides with a run request
  `PRD_ASSERT_NOW(a_task, clk_i, rst_ni, m_axis_tvalid_o && (m_axis_tdata_o[1:0] != '0), m_axis_tuser_o[0], "task index without run request")

endmodule

bind periodic_release_dispatcher_top prd_checker u_prd_checker (.*);
